/* sv/half_perimeter_wirelength_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the half-perimeter wirelength block
// Shared concurrent checks, clocked on clk and quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef HALF_PERIMETER_WIRELENGTH_TOP_MACROS_SVH
`define HALF_PERIMETER_WIRELENGTH_TOP_MACROS_SVH

// Same-cycle implication.
`define HPWL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hpwl check failed");

// Next-cycle implication.
`define HPWL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hpwl check failed");

`endif

/* sv/hpwl_pkg.sv */
// ----------------------------------------------------------------------------
// hpwl_pkg
// Types and widths shared by the wirelength front end, back end and queues.
// ----------------------------------------------------------------------------
package hpwl_pkg;

	localparam int IN_W    = 32;
	localparam int COORD_W = 33;
	localparam int TOTAL_W = 64;

	// Item in the middle queue: pin position plus its class.
	typedef struct packed {
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		logic                      net_end;
		logic                      design_end;
	} pin_t;

	// Item in the result queue.
	typedef struct packed {
		logic [COORD_W-1:0] net_width;
		logic [COORD_W-1:0] net_height;
		logic [TOTAL_W-1:0] sum_x;
		logic [TOTAL_W-1:0] sum_y;
		logic [TOTAL_W-1:0] sum_both;
		logic               run_done;
	} res_t;

endpackage

/* sv/hpwl_fifo.sv */
// ----------------------------------------------------------------------------
// hpwl_fifo
// Small register queue with push/full and pop/empty; head is always shown.
// ----------------------------------------------------------------------------
module hpwl_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Storage carries no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

/* sv/hpwl_front.sv */
// ----------------------------------------------------------------------------
// hpwl_front
// Form the pin position and classify the item as it enters the queue.
// ----------------------------------------------------------------------------
module hpwl_front (
	input  logic                              push,
	output logic                              full,
	input  logic signed [hpwl_pkg::IN_W-1:0]  cell_center_x,
	input  logic signed [hpwl_pkg::IN_W-1:0]  cell_center_y,
	input  logic signed [hpwl_pkg::IN_W-1:0]  pin_offset_x,
	input  logic signed [hpwl_pkg::IN_W-1:0]  pin_offset_y,
	input  logic                              net_end,
	input  logic                              design_end,
	output logic                              mid_push,
	output hpwl_pkg::pin_t                    mid_item,
	input  logic                              mid_full
);

	import hpwl_pkg::*;

	// Exact 33-bit sums; design end also closes the net.
	always_comb begin
		mid_item.px         = COORD_W'(cell_center_x) + COORD_W'(pin_offset_x);
		mid_item.py         = COORD_W'(cell_center_y) + COORD_W'(pin_offset_y);
		mid_item.net_end    = net_end || design_end;
		mid_item.design_end = design_end;
	end

	assign full     = mid_full;
	assign mid_push = push;

endmodule

/* sv/hpwl_back.sv */
// ----------------------------------------------------------------------------
// hpwl_back
// Grow the net box, take its extent, accumulate saturating totals.
// ----------------------------------------------------------------------------
module hpwl_back (
	input  logic           clk,
	input  logic           arst_n,
	input  hpwl_pkg::pin_t mid_item,
	input  logic           mid_empty,
	output logic           mid_pop,
	input  logic           out_full,
	output logic           out_push,
	output hpwl_pkg::res_t out_item
);

	import hpwl_pkg::*;

	logic en;

	// Open box state
	logic                      box_open_q;
	logic signed [COORD_W-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
	logic signed [COORD_W-1:0] nmin_x, nmax_x, nmin_y, nmax_y;
	logic                      take;

	// Stage 1: closed box
	logic                      v_s1, done_s1;
	logic signed [COORD_W-1:0] min_x_s1, max_x_s1, min_y_s1, max_y_s1;

	// Stage 2: extent
	logic                      v_s2, done_s2;
	logic [COORD_W-1:0]        w_s2, h_s2;

	// Stage 3: totals
	logic                      v_s3, done_s3;
	logic [COORD_W-1:0]        w_s3, h_s3;
	logic [TOTAL_W-1:0]        tx_s3, ty_s3;
	logic [TOTAL_W-1:0]        total_x_q, total_y_q;
	logic [TOTAL_W:0]          tx_sum, ty_sum, both_sum;
	logic [TOTAL_W-1:0]        tx_next, ty_next;
	logic [COORD_W:0]          dx, dy;

	// Hold the whole pipe while the result queue is full.
	assign en      = !out_full;
	assign mid_pop = en && !mid_empty;
	assign take    = mid_pop;

	always_comb begin
		if (box_open_q) begin
			nmin_x = (mid_item.px < min_x_q) ? mid_item.px : min_x_q;
			nmax_x = (mid_item.px > max_x_q) ? mid_item.px : max_x_q;
			nmin_y = (mid_item.py < min_y_q) ? mid_item.py : min_y_q;
			nmax_y = (mid_item.py > max_y_q) ? mid_item.py : max_y_q;
		end else begin
			nmin_x = mid_item.px;
			nmax_x = mid_item.px;
			nmin_y = mid_item.py;
			nmax_y = mid_item.py;
		end
	end

	always_comb begin
		dx      = {max_x_s1[COORD_W-1], max_x_s1} - {min_x_s1[COORD_W-1], min_x_s1};
		dy      = {max_y_s1[COORD_W-1], max_y_s1} - {min_y_s1[COORD_W-1], min_y_s1};
		tx_sum  = {1'b0, total_x_q} + (TOTAL_W + 1)'(w_s2);
		ty_sum  = {1'b0, total_y_q} + (TOTAL_W + 1)'(h_s2);
		tx_next = tx_sum[TOTAL_W] ? '1 : tx_sum[TOTAL_W-1:0];
		ty_next = ty_sum[TOTAL_W] ? '1 : ty_sum[TOTAL_W-1:0];
		both_sum = {1'b0, tx_s3} + {1'b0, ty_s3};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_open_q <= 1'b0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			total_x_q  <= '0;
			total_y_q  <= '0;
		end else if (en) begin
			v_s1 <= take && mid_item.net_end;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (take) begin
				box_open_q <= !mid_item.net_end;
			end
			if (v_s2) begin
				total_x_q <= done_s2 ? '0 : tx_next;
				total_y_q <= done_s2 ? '0 : ty_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (take) begin
				min_x_q <= nmin_x;
				max_x_q <= nmax_x;
				min_y_q <= nmin_y;
				max_y_q <= nmax_y;
			end
			min_x_s1 <= nmin_x;
			max_x_s1 <= nmax_x;
			min_y_s1 <= nmin_y;
			max_y_s1 <= nmax_y;
			done_s1  <= mid_item.design_end;
			w_s2     <= dx[COORD_W-1:0];
			h_s2     <= dy[COORD_W-1:0];
			done_s2  <= done_s1;
			w_s3     <= w_s2;
			h_s3     <= h_s2;
			tx_s3    <= tx_next;
			ty_s3    <= ty_next;
			done_s3  <= done_s2;
		end
	end

	assign out_push = en && v_s3;

	always_comb begin
		out_item.net_width  = w_s3;
		out_item.net_height = h_s3;
		out_item.sum_x      = tx_s3;
		out_item.sum_y      = ty_s3;
		out_item.sum_both   = both_sum[TOTAL_W] ? '1 : both_sum[TOTAL_W-1:0];
		out_item.run_done   = done_s3;
	end

endmodule

/* sv/half_perimeter_wirelength_top.sv */
// An accepted item passes the middle queue, stages s1, s2 and s3, then the result queue.
// Throughput: one pin item per cycle; the back end holds only while the result queue is full.
// A net result appears for each item with net_end or design_end set; other items yield none.
// Reset (arst_n low, asynchronous) empties both queues, closes the open box and zeroes totals.
// ----------------------------------------------------------------------------
// half_perimeter_wirelength_top
// Half-perimeter wirelength accumulator: pin queue front, box/total back end.
// ----------------------------------------------------------------------------
`include "half_perimeter_wirelength_top_macros.svh"

module half_perimeter_wirelength_top #(
	parameter int MID_DEPTH = 4,
	parameter int OUT_DEPTH = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic signed [hpwl_pkg::IN_W-1:0]      cell_center_x,
	input  logic signed [hpwl_pkg::IN_W-1:0]      cell_center_y,
	input  logic signed [hpwl_pkg::IN_W-1:0]      pin_offset_x,
	input  logic signed [hpwl_pkg::IN_W-1:0]      pin_offset_y,
	input  logic                                  net_end,
	input  logic                                  design_end,
	output logic                                  empty,
	input  logic                                  pop,
	output logic [hpwl_pkg::COORD_W-1:0]          net_width,
	output logic [hpwl_pkg::COORD_W-1:0]          net_height,
	output logic [hpwl_pkg::TOTAL_W-1:0]          sum_x,
	output logic [hpwl_pkg::TOTAL_W-1:0]          sum_y,
	output logic [hpwl_pkg::TOTAL_W-1:0]          sum_both,
	output logic                                  run_done
);

	import hpwl_pkg::*;

	// Front to back queue
	logic mid_push, mid_full, mid_pop, mid_empty;
	pin_t mid_witem, mid_ritem;
	logic [$bits(pin_t)-1:0] mid_rdata;

	// Back to result queue
	logic out_push, out_full;
	res_t out_witem, out_ritem;
	logic [$bits(res_t)-1:0] out_rdata;

	// Front: add cell center and pin offset, fold design end into net end.
	hpwl_front u_front (
		.push          (push),
		.full          (full),
		.cell_center_x (cell_center_x),
		.cell_center_y (cell_center_y),
		.pin_offset_x  (pin_offset_x),
		.pin_offset_y  (pin_offset_y),
		.net_end       (net_end),
		.design_end    (design_end),
		.mid_push      (mid_push),
		.mid_item      (mid_witem),
		.mid_full      (mid_full)
	);

	// Decouple the input side from back-end stalls.
	hpwl_fifo #(
		.WIDTH ($bits(pin_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_witem),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	assign mid_ritem = mid_rdata;

	// Back: grow the box, close nets, accumulate saturating totals.
	hpwl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_item  (mid_ritem),
		.mid_empty (mid_empty),
		.mid_pop   (mid_pop),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_item  (out_witem)
	);

	// Result queue: holds finished nets until the consumer pops them.
	hpwl_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_witem),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_rdata),
		.empty  (empty)
	);

	assign out_ritem  = out_rdata;
	assign net_width  = out_ritem.net_width;
	assign net_height = out_ritem.net_height;
	assign sum_x      = out_ritem.sum_x;
	assign sum_y      = out_ritem.sum_y;
	assign sum_both   = out_ritem.sum_both;
	assign run_done   = out_ritem.run_done;

	// An accepted item must land in the middle queue.
	`HPWL_ASSERT_NEXT(a_accept_lands, push && !full, !mid_empty)
	// Saturating combined total never falls below either part.
	`HPWL_ASSERT_NOW(a_both_covers, !empty, (sum_both >= sum_x) && (sum_both >= sum_y))
	// The running totals already include this net.
	`HPWL_ASSERT_NOW(a_total_covers, !empty, (sum_x >= 64'(net_width)) && (sum_y >= 64'(net_height)))

endmodule
